@@ rtl/h264_slice_header_scanner_defines.svh @@
// Assertion macros for the slice header scanner.
// Included by the files that carry concurrent checks; needs nothing else.
`ifndef H264_SLICE_HEADER_SCANNER_DEFINES_SVH
`define H264_SLICE_HEADER_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SHS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slice header scanner check failed");
// Next-cycle implication, disabled while reset is asserted.
`define SHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slice header scanner check failed");
`else
`define SHS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/h264shs_pkg.sv @@
// Shared types, constants and helpers of the slice header scanner.
// Used by the window, the decoder and the top level.
package h264shs_pkg;

	localparam int WinLen = 9;

	localparam logic [5:0]  WIDTH_UNLEARNED = 6'd63;
	localparam logic [31:0] TIME_STEP       = 32'd88;
	localparam logic [15:0] MIN_SKIP_LEN    = 16'd5;

	localparam logic [7:0] NAL_HDR_21 = 8'h21;
	localparam logic [7:0] NAL_HDR_25 = 8'h25;
	localparam logic [7:0] NAL_HDR_41 = 8'h41;
	localparam logic [7:0] NAL_HDR_45 = 8'h45;
	localparam logic [7:0] NAL_HDR_61 = 8'h61;
	localparam logic [7:0] NAL_HDR_65 = 8'h65;

	localparam logic [7:0] PAT_I5_MASK = 8'hF8;
	localparam logic [7:0] PAT_I5_VAL  = 8'hB8;
	localparam logic [7:0] PAT_I9_VAL  = 8'h88;
	localparam logic [7:0] PAT_P3_MASK = 8'hE0;
	localparam logic [7:0] PAT_P3_VAL  = 8'hE0;
	localparam logic [7:0] PAT_P7_MASK = 8'hFE;
	localparam logic [7:0] PAT_P7_VAL  = 8'h9A;

	typedef logic [WinLen-1:0][7:0] window_t;

	typedef struct packed {
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] nal_size;
		logic        is_intra;
		logic [27:0] frame_number;
		logic        accepted;
		logic [31:0] present_time;
	} hdr_item_t;

	// Decoder verdict on the current window.
	typedef struct packed {
		logic        hit;
		logic        intra;
		logic [15:0] len;
		logic [5:0]  width_next;
		logic [27:0] num;
	} dec_t;

	function automatic logic nal_header_ok(input logic [7:0] h);
		return (h == NAL_HDR_21) || (h == NAL_HDR_25) || (h == NAL_HDR_41) ||
		       (h == NAL_HDR_45) || (h == NAL_HDR_61) || (h == NAL_HDR_65);
	endfunction

endpackage

@@ rtl/h264shs_chan_if.sv @@
// Valid/ready channel carrying one request payload.
// Payload type is a parameter; the scanner uses types from h264shs_pkg.
interface h264shs_chan_if #(parameter type payload_t = logic [7:0]) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/h264shs_window.sv @@
// Nine-byte sliding window of the stream, oldest byte at index 0.
// Depends on h264shs_pkg for the window type.
module h264shs_window (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift_en,
	input  logic [7:0]          new_byte,
	output h264shs_pkg::window_t win_next
);
	import h264shs_pkg::*;

	window_t win_q;

	// The decoder looks at the window as it will be after this byte.
	assign win_next = {new_byte, win_q[WinLen-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift_en) begin
			win_q <= win_next;
		end
	end
endmodule

@@ rtl/h264shs_decode.sv @@
// Slice header decoder: pattern match, frame number width learning and extraction.
// Purely combinational; depends on h264shs_pkg.
module h264shs_decode (
	input  h264shs_pkg::window_t win,
	input  logic [5:0]           number_width,
	output h264shs_pkg::dec_t    dec
);
	import h264shs_pkg::*;

	logic [31:0] word;
	logic [31:0] lead;
	logic [31:0] srch;
	logic        pat_hit;
	logic        intra;
	logic [5:0]  first_pos;
	logic [5:0]  width_next;

	assign word = {win[5], win[6], win[7], win[8]};

	// The search never looks at the bit position where the last word bit lands.
	always_comb begin
		pat_hit = 1'b1;
		intra   = 1'b0;
		lead    = '0;
		srch    = '0;
		priority if ((win[5] & PAT_I5_MASK) == PAT_I5_VAL) begin
			intra = 1'b1;
			lead  = word << 5;
			srch  = lead & (32'hFFFF_FFFF << 6);
		end else if (win[5] == PAT_I9_VAL && win[6][7]) begin
			intra = 1'b1;
			lead  = word << 9;
			srch  = lead & (32'hFFFF_FFFF << 10);
		end else if ((win[5] & PAT_P3_MASK) == PAT_P3_VAL) begin
			lead = word << 3;
			srch = lead & (32'hFFFF_FFFF << 4);
		end else if ((win[5] & PAT_P7_MASK) == PAT_P7_VAL) begin
			lead = word << 7;
			srch = lead & (32'hFFFF_FFFF << 8);
		end else begin
			pat_hit = 1'b0;
		end
	end

	// Priority encoder: the most significant set bit wins, width counts from 1.
	always_comb begin
		first_pos = '0;
		for (int i = 0; i < 32; i++) begin
			if (srch[i]) begin
				first_pos = 6'(32 - i);
			end
		end
	end

	always_comb begin
		if (number_width == WIDTH_UNLEARNED) begin
			width_next = '0;
		end else if (number_width == '0 && srch != '0) begin
			width_next = first_pos;
		end else begin
			width_next = number_width;
		end
	end

	always_comb begin
		dec.hit        = (win[0] == '0) && (win[1] == '0) && nal_header_ok(win[4]) && pat_hit;
		dec.intra      = intra;
		dec.len        = {win[2], win[3]};
		dec.width_next = width_next;
		if (width_next != '0 && width_next <= 6'd31) begin
			dec.num = 28'(lead >> (6'd32 - width_next));
		end else begin
			dec.num = '0;
		end
	end
endmodule

@@ rtl/h264_slice_header_scanner.sv @@
// Slice header scanner for a length-prefixed H.264 byte stream.
// The stream channel takes one data_byte per request; the header channel gives
// one request per slice header that is found and has a nonzero NAL length.
// Each result carries the NAL length, slice kind, frame number, whether it is
// accepted (a P slice must follow the last accepted one) and presentation time.
// Throughput: one byte per cycle while the receiver does not stall. A byte is
// held in the input register; window shift, header match and frame number
// priority encode run combinationally into the output register, which offers
// the result. After an accepted header the next (length - 5) bytes, none for a
// length under 5, are consumed at the same rate without entering the window.
// When the receiver stalls, the output register holds its request; the input
// register takes one more byte only if empty, then the stream side stalls too.
// Reset clears the window, the skip count, the time and the last frame number,
// and marks the frame number width as not yet learned. No clearing pass runs.
// Depends on h264shs_pkg, h264shs_chan_if, h264shs_window and h264shs_decode.
`include "h264_slice_header_scanner_defines.svh"

module h264_slice_header_scanner (
	input  logic           clk,
	input  logic           arst_n,
	h264shs_chan_if.sink   stream,
	h264shs_chan_if.source header
);
	import h264shs_pkg::*;

	logic        valid_s1;
	in_item_t    item_s1;
	logic        fire;
	logic        skipping;
	logic        shift_en;
	logic        hdr_seen;
	logic        res_load;
	logic        rejected;
	logic        out_valid_q;
	hdr_item_t   out_q;
	logic [15:0] skip_left_q;
	logic [5:0]  number_width_q;
	logic [27:0] last_number_q;
	logic [31:0] time_accum_q;
	window_t     win_next;
	dec_t        dec;

	assign fire         = valid_s1 && (!out_valid_q || header.ready);
	assign stream.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			item_s1 <= stream.payload;
		end
	end

	assign skipping = (skip_left_q != '0);
	assign shift_en = fire && !skipping;

	h264shs_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (shift_en),
		.new_byte (item_s1.data_byte),
		.win_next (win_next)
	);

	h264shs_decode u_decode (
		.win          (win_next),
		.number_width (number_width_q),
		.dec          (dec)
	);

	assign hdr_seen = shift_en && dec.hit;
	assign res_load = hdr_seen && (dec.len != '0);
	assign rejected = !dec.intra && ({1'b0, dec.num} != ({1'b0, last_number_q} + 29'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_left_q    <= '0;
			number_width_q <= WIDTH_UNLEARNED;
			last_number_q  <= '0;
			time_accum_q   <= '0;
		end else begin
			if (fire && skipping) begin
				skip_left_q <= skip_left_q - 16'd1;
			end
			if (hdr_seen) begin
				number_width_q <= dec.width_next;
			end
			if (res_load && !rejected) begin
				last_number_q <= dec.num;
				time_accum_q  <= time_accum_q + TIME_STEP;
				skip_left_q   <= (dec.len >= MIN_SKIP_LEN) ? (dec.len - MIN_SKIP_LEN) : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (header.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q.nal_size     <= dec.len;
			out_q.is_intra     <= dec.intra;
			out_q.frame_number <= dec.num;
			out_q.accepted     <= !rejected;
			out_q.present_time <= time_accum_q;
		end
	end

	assign header.valid   = out_valid_q;
	assign header.payload = out_q;

	// Bytes inside a skipped payload never produce a header.
	`SHS_ASSERT_IMPLY(a_skip_quiet, clk, arst_n, fire && skipping, !res_load)
	// Only P slices can be rejected.
	`SHS_ASSERT_IMPLY(a_reject_p_only, clk, arst_n, out_valid_q && !out_q.accepted, !out_q.is_intra)
	// Once a header has been seen the width never returns to the unlearned marker.
	`SHS_ASSERT_NEXT(a_width_sticky, clk, arst_n, number_width_q != WIDTH_UNLEARNED,
		number_width_q != WIDTH_UNLEARNED)
	// An accepted header advances the time by one frame step.
	`SHS_ASSERT_NEXT(a_time_step, clk, arst_n, res_load && !rejected,
		time_accum_q == ($past(time_accum_q) + TIME_STEP))
endmodule
